### sv/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared types and constants for the global constraint checker: mode codes,
// controller states and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gcc_pkg;

	localparam int MAX_DISTINCT_DEF = 64;
	localparam int VALUE_BITS_DEF   = 32;
	localparam int COUNT_OUT_W      = 7;
	localparam int ITEMS_W          = 16;
	localparam int MODE_W           = 2;

	typedef logic [MODE_W-1:0] mode_t;

	localparam mode_t MODE_ALLDIFF = 2'd0;
	localparam mode_t MODE_SUM     = 2'd1;
	localparam mode_t MODE_NVALUES = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REPORT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture an accepted item
		logic scan_rd;   // read the next stored value and advance the index
		logic mark_dup;  // the item matched a stored value
		logic insert;    // add the item to the set store
		logic accum;     // add the item to the running sum
		logic report;    // load the result register and clear the tuple
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic needs_set;   // the held item goes through the set store
		logic match;       // the value read last cycle equals the held item
		logic scan_more;   // stored entries remain to be read
		logic rd_pending;  // a read issued last cycle returns now
		logic last;        // the held item closes the tuple
		logic out_free;    // the result register can take a new result
	} status_t;

endpackage

### sv/global_constraint_checker.sv
// ----------------------------------------------------------------------------
// global_constraint_checker
// Checks all-distinct, sum and distinct-count constraints over tuples of
// signed values, keeping seen values in a bounded set store.
// ----------------------------------------------------------------------------
// A new item is taken only once the previous one is done. An item that uses the
//   store is checked by a one-value-per-cycle scan of the stored values, which a
//   match ends early; modes other than all-distinct skip the store for a last item.
//   A last item then goes to the report state, which waits while an earlier result
//   is held and then loads the result register that drives out_valid.
// Reset: arst_n clears the tuple state, the mode (to all-distinct) and out_valid.
module global_constraint_checker #(
	parameter int MAX_DISTINCT = gcc_pkg::MAX_DISTINCT_DEF,
	parameter int VALUE_BITS   = gcc_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration: the mode register.
	input  logic                            cfg_we,
	input  logic [gcc_pkg::MODE_W-1:0]      cfg_wdata,
	// Input items.
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [VALUE_BITS-1:0]    value,
	input  logic                            last,
	// Result items.
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            satisfied,
	output logic [gcc_pkg::COUNT_OUT_W-1:0] distinct_count,
	output logic                            malformed,
	output logic                            capacity_exceeded
);
	import gcc_pkg::*;

	// The controller and datapath talk only through these two groups. The
	// controller sequences each item: capture, for items that use the store a
	// scan one entry per cycle with the compare in the cycle after the read,
	// then either a duplicate mark or an insertion, and on the last item a report.
	cmd_t    cmd;
	status_t st;

	gcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// The datapath holds the item, the store and its fill count, the sum,
	// the tuple flags and the result register. The result register frees
	// the input side: new items are taken while a result waits.
	gcc_dp #(
		.MAX_DISTINCT(MAX_DISTINCT),
		.VALUE_BITS  (VALUE_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.st                (st),
		.value             (value),
		.last              (last),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.satisfied         (satisfied),
		.distinct_count    (distinct_count),
		.malformed         (malformed),
		.capacity_exceeded (capacity_exceeded)
	);

endmodule

### sv/gcc_ram.sv
// ----------------------------------------------------------------------------
// gcc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gcc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/gcc_ctrl.sv
// ----------------------------------------------------------------------------
// gcc_ctrl
// Controller: accepts items, steps the set-store scan one entry per cycle,
// decides between duplicate and insertion, and hands results to the output.
// ----------------------------------------------------------------------------
module gcc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gcc_pkg::status_t st,
	output gcc_pkg::cmd_t    cmd
);
	import gcc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!st.needs_set) begin
					state_d = ST_REPORT;
				end else if (st.match) begin
					cmd.mark_dup = 1'b1;
					cmd.accum    = !st.last;
					state_d      = st.last ? ST_REPORT : ST_IDLE;
				end else if (st.scan_more) begin
					cmd.scan_rd = 1'b1;
				end else if (!st.rd_pending) begin
					cmd.insert = 1'b1;
					cmd.accum  = !st.last;
					state_d    = st.last ? ST_REPORT : ST_IDLE;
				end
			end
			ST_REPORT: begin
				if (st.out_free) begin
					cmd.report = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A value is either found in the store or inserted, never both.
	a_dup_or_insert: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mark_dup && cmd.insert))
		else $error("duplicate and insert in the same cycle");

	// The scan ends only once the last issued read has been compared.
	a_no_insert_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !st.rd_pending)
		else $error("insert while a compare is outstanding");

	// A result is only loaded when the result register can take it.
	a_report_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.report |-> st.out_free)
		else $error("report while the result register is still held");

endmodule

### sv/gcc_dp.sv
// ----------------------------------------------------------------------------
// gcc_dp
// Datapath: holds the current item, the set store with its fill count, the
// running sum and tuple flags, the mode register and the result register.
// ----------------------------------------------------------------------------
module gcc_dp #(
	parameter int MAX_DISTINCT = gcc_pkg::MAX_DISTINCT_DEF,
	parameter int VALUE_BITS   = gcc_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gcc_pkg::cmd_t                       cmd,
	output gcc_pkg::status_t                    st,
	input  logic signed [VALUE_BITS-1:0]        value,
	input  logic                                last,
	input  logic                                cfg_we,
	input  logic [gcc_pkg::MODE_W-1:0]          cfg_wdata,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                satisfied,
	output logic [gcc_pkg::COUNT_OUT_W-1:0]     distinct_count,
	output logic                                malformed,
	output logic                                capacity_exceeded
);
	import gcc_pkg::*;

	localparam int AW   = $clog2(MAX_DISTINCT);
	localparam int CW   = $clog2(MAX_DISTINCT + 1);
	localparam int CMPW = (CW > VALUE_BITS) ? CW : VALUE_BITS;
	localparam logic [CW-1:0]      COUNT_MAX = CW'(MAX_DISTINCT);
	localparam logic [ITEMS_W-1:0] ITEMS_SAT = '1;

	logic [VALUE_BITS-1:0] value_q;
	logic                  last_q;
	logic [ITEMS_W-1:0]    items_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         idx_q;
	logic [VALUE_BITS-1:0] sum_q;
	logic                  dup_q;
	logic                  ovf_q;
	mode_t                 mode_q;
	logic                  rd_v_s1;
	logic [VALUE_BITS-1:0] rdata;
	logic                  mem_we;

	logic res_sat;
	logic res_bad;

	assign mem_we = cmd.insert && (count_q != COUNT_MAX);

	gcc_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(MAX_DISTINCT)
	) u_seen (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[AW-1:0]),
		.wdata (value_q),
		.re    (cmd.scan_rd),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ALLDIFF;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
			last_q  <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
			sum_q   <= '0;
			dup_q   <= 1'b0;
			ovf_q   <= 1'b0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				idx_q <= '0;
				if (items_q != ITEMS_SAT) begin
					items_q <= items_q + 1'b1;
				end
			end else if (cmd.scan_rd) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.mark_dup) begin
				dup_q <= 1'b1;
			end
			if (cmd.insert) begin
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.accum) begin
				sum_q <= sum_q + value_q;
			end
			if (cmd.report) begin
				items_q <= '0;
				count_q <= '0;
				sum_q   <= '0;
				dup_q   <= 1'b0;
				ovf_q   <= 1'b0;
			end
		end
	end

	always_comb begin
		res_sat = 1'b0;
		res_bad = 1'b0;
		case (mode_q)
			MODE_ALLDIFF: begin
				res_sat = !dup_q;
			end
			MODE_SUM: begin
				res_bad = (items_q < ITEMS_W'(2));
				res_sat = !res_bad && (sum_q == value_q);
			end
			MODE_NVALUES: begin
				res_bad = (items_q < ITEMS_W'(2)) || value_q[VALUE_BITS-1]
					|| (value_q == '0);
				res_sat = !res_bad && (CMPW'(count_q) == CMPW'(value_q));
			end
			default: begin
				res_sat = 1'b0;
			end
		endcase
		if (ovf_q) begin
			res_sat = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.report) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.report) begin
			satisfied         <= res_sat;
			distinct_count    <= COUNT_OUT_W'(count_q);
			malformed         <= res_bad;
			capacity_exceeded <= ovf_q;
		end
	end

	assign st.needs_set  = !last_q || (mode_q == MODE_ALLDIFF);
	assign st.match      = rd_v_s1 && (rdata == value_q);
	assign st.scan_more  = (idx_q < count_q);
	assign st.rd_pending = rd_v_s1;
	assign st.last       = last_q;
	assign st.out_free   = !out_valid || out_ready;

	// The fill count never passes the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_MAX)
		else $error("set store count beyond its depth");

	// Inserting into a full store marks the tuple as overflowed.
	a_overflow_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert && !cmd.report && (count_q == COUNT_MAX) |=> ovf_q)
		else $error("full store insert did not set overflow");

	// A report leaves an empty tuple behind.
	a_report_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.report |=> (count_q == '0) && (items_q == '0) && !dup_q && !ovf_q)
		else $error("tuple state not cleared after report");

	// Reads never run past the filled part of the store.
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> (idx_q < count_q))
		else $error("store read beyond fill count");

endmodule

### tb/tb_global_constraint_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_global_constraint_checker
// Self-checking bench for the global constraint checker. It streams tuples
// of signed values through the valid/ready input, predicts each tuple's
// verdict in a scoreboard class, and checks every result item field by field
// across all mode codes and several idling patterns.
// ----------------------------------------------------------------------------
module tb_global_constraint_checker;
	import gcc_pkg::*;

	localparam int SET_DEPTH    = MAX_DISTINCT_DEF;
	localparam int VW           = VALUE_BITS_DEF;
	localparam int CLK_HALF     = 5;
	// The slowest item needs a full scan of the store and, if it is the last, a
	// report, so this covers any work still in flight.
	localparam int DRAIN_CYCLES = SET_DEPTH + 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 400;
	localparam int N_PHASES     = 8;
	localparam longint TIMEOUT_NS = 64'd20_000_000;

	// Code 3 has no name in the package; the block treats it as an unused mode.
	localparam mode_t MODE_UNUSED = 2'd3;

	typedef logic [VW-1:0] word_t;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;
	typedef enum int {FILL_SMALL, FILL_WIDE, FILL_EDGE} fill_t;

	typedef struct packed {
		logic                   sat;
		logic [COUNT_OUT_W-1:0] count;
		logic                   bad;
		logic                   ovf;
	} verdict_t;

	// Tracks the tuple in progress exactly as the block should, and keeps the
	// verdicts of closed tuples until the block reports them.
	class verdict_scoreboard;
		mode_t              mode;
		word_t              seen[SET_DEPTH];
		int unsigned        seen_n;
		word_t              sum;
		logic               dup;
		logic               ovf;
		logic [ITEMS_W-1:0] n_items;
		verdict_t           pending_verdicts[$];
		int                 errors;
		int                 items_seen;
		int                 verdicts_seen;

		function new();
			mode = MODE_ALLDIFF;
			errors = 0;
			items_seen = 0;
			verdicts_seen = 0;
			clear_tuple();
		endfunction

		function void clear_tuple();
			seen_n = 0;
			sum = '0;
			dup = 1'b0;
			ovf = 1'b0;
			n_items = '0;
		endfunction

		function void set_mode(mode_t m);
			mode = m;
		endfunction

		// A value already present marks a duplicate; a new one that finds the
		// store full is dropped and flags the overflow.
		function void store_value(word_t v);
			for (int i = 0; i < seen_n; i++) begin
				if (seen[i] == v) begin
					dup = 1'b1;
					return;
				end
			end
			if (seen_n < SET_DEPTH) begin
				seen[seen_n] = v;
				seen_n++;
			end else begin
				ovf = 1'b1;
			end
		endfunction

		function void note_item(word_t v, logic is_last);
			verdict_t vd;
			vd = '0;
			items_seen++;
			if (n_items != '1)
				n_items++;
			if (!is_last) begin
				store_value(v);
				sum += v;
				return;
			end
			case (mode)
				MODE_ALLDIFF: begin
					store_value(v);
					vd.sat = !dup;
				end
				MODE_SUM: begin
					vd.bad = n_items < 2;
					vd.sat = !vd.bad && sum == v;
				end
				MODE_NVALUES: begin
					vd.bad = n_items < 2 || v[VW-1] || v == '0;
					vd.sat = !vd.bad && word_t'(seen_n) == v;
				end
				default: begin
					vd.sat = 1'b0;
				end
			endcase
			if (ovf)
				vd.sat = 1'b0;
			vd.count = seen_n[COUNT_OUT_W-1:0];
			vd.ovf = ovf;
			pending_verdicts.push_back(vd);
			clear_tuple();
		endfunction

		function void check_verdict(verdict_t got);
			verdict_t want;
			verdicts_seen++;
			if (pending_verdicts.size() == 0) begin
				$error("result item with no tuple outstanding");
				errors++;
				return;
			end
			want = pending_verdicts.pop_front();
			if (got.sat !== want.sat) begin
				$error("satisfied: expected %0b, got %0b", want.sat, got.sat);
				errors++;
			end
			if (got.count !== want.count) begin
				$error("distinct_count: expected %0d, got %0d", want.count, got.count);
				errors++;
			end
			if (got.bad !== want.bad) begin
				$error("malformed: expected %0b, got %0b", want.bad, got.bad);
				errors++;
			end
			if (got.ovf !== want.ovf) begin
				$error("capacity_exceeded: expected %0b, got %0b", want.ovf, got.ovf);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [MODE_W-1:0]      cfg_wdata;
	logic                   in_valid;
	logic                   in_ready;
	logic signed [VW-1:0]   value;
	logic                   last;
	logic                   out_valid;
	logic                   out_ready;
	logic                   satisfied;
	logic [COUNT_OUT_W-1:0] distinct_count;
	logic                   malformed;
	logic                   capacity_exceeded;

	verdict_scoreboard board = new();

	// Idling controls shared between the sender, the receiver and the phases.
	int gap_pct   = 0;
	int stall_pct = 0;
	bit hold_req  = 1'b0;

	// The tuple about to be sent; the last entry carries the last flag.
	word_t tuple_vals[$];

	global_constraint_checker u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.value             (value),
		.last              (last),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.satisfied         (satisfied),
		.distinct_count    (distinct_count),
		.malformed         (malformed),
		.capacity_exceeded (capacity_exceeded)
	);

	always #CLK_HALF clk = ~clk;

	// Both handshakes are sampled at the rising edge, where every signal still
	// holds the value it had before the edge, so sampling order does not matter.
	always @(posedge clk) begin : handshake_monitor
		verdict_t got;
		if (arst_n && in_valid && in_ready)
			board.note_item(value, last);
		if (arst_n && out_valid && out_ready) begin
			got = {satisfied, distinct_count, malformed, capacity_exceeded};
			board.check_verdict(got);
		end
	end

	// Result receiver. Normally it stalls at random at the current rate; on a
	// hold request it keeps ready low for a long stretch that it counts itself,
	// so the block backs up while the sender keeps offering items.
	initial begin : result_receiver
		int hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offers one item and returns once it has been accepted. An idle gap, when
	// one is drawn, comes before the item so valid never drops while offered.
	task automatic send_item(word_t v, logic is_last);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		last <= is_last;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic send_tuple();
		for (int i = 0; i < tuple_vals.size(); i++)
			send_item(tuple_vals[i], i == tuple_vals.size() - 1);
	endtask

	task automatic add_run(word_t base, word_t stride, int n);
		for (int i = 0; i < n; i++)
			tuple_vals.push_back(base + word_t'(i) * stride);
	endtask

	// Waits until every closed tuple has reported, then lets any trailing work
	// on items that report nothing run out.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The mode only changes while the block is idle.
	task automatic write_mode(mode_t m);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_mode(m);
	endtask

	task automatic set_idling(idling_t kind);
		case (kind)
			IDLE_NONE: begin
				gap_pct = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				gap_pct = 65;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				gap_pct = 0;
				stall_pct = 65;
			end
			default: begin
				gap_pct = 21;
				stall_pct = 21;
			end
		endcase
	endtask

	function automatic word_t pick_value(fill_t kind);
		case (kind)
			FILL_SMALL: return word_t'($urandom_range(7)) - word_t'(4);
			FILL_WIDE:  return word_t'($urandom());
			default: begin
				case ($urandom_range(4))
					0: return {1'b1, {(VW-1){1'b0}}};
					1: return {1'b0, {(VW-1){1'b1}}};
					2: return '0;
					3: return '1;
					default: return word_t'($urandom_range(7)) - word_t'(4);
				endcase
			end
		endcase
	endfunction

	// Builds one random tuple. Most are short and well formed for the mode, with
	// a closing value that, in the sum and distinct-count modes, meets the
	// constraint more often than not; a few outgrow the set store.
	task automatic make_random_tuple(mode_t m);
		int    len;
		int    roll;
		int    n_distinct;
		bit    fresh;
		fill_t kind;
		word_t acc;
		word_t base;
		word_t closing;
		tuple_vals.delete();
		roll = $urandom_range(99);
		kind = fill_t'($urandom_range(2));
		if (roll < 2) begin
			len = $urandom_range(SET_DEPTH + 1, SET_DEPTH + 4);
			base = word_t'($urandom());
			add_run(base, word_t'($urandom_range(1, 9)), len - 1);
		end else begin
			len = (roll < 12) ? 1 : $urandom_range(2, 12);
			for (int i = 0; i < len - 1; i++)
				tuple_vals.push_back(pick_value(kind));
		end

		acc = '0;
		n_distinct = 0;
		for (int i = 0; i < tuple_vals.size(); i++) begin
			acc += tuple_vals[i];
			fresh = 1'b1;
			for (int j = 0; j < i; j++)
				if (tuple_vals[j] == tuple_vals[i])
					fresh = 1'b0;
			if (fresh && n_distinct < SET_DEPTH)
				n_distinct++;
		end

		case (m)
			MODE_SUM: begin
				if ($urandom_range(99) < 60)
					closing = acc;
				else
					closing = acc + pick_value(kind);
			end
			MODE_NVALUES: begin
				case ($urandom_range(9))
					0: closing = '0;
					1: closing = '1;
					2: closing = word_t'(n_distinct + 1);
					3: closing = word_t'($urandom());
					default: closing = word_t'(n_distinct);
				endcase
			end
			default: begin
				if (tuple_vals.size() != 0 && $urandom_range(3) == 0)
					closing = tuple_vals[$urandom_range(tuple_vals.size() - 1)];
				else
					closing = pick_value(kind);
			end
		endcase
		tuple_vals.push_back(closing);
	endtask

	task automatic run_phase(int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			make_random_tuple(board.mode);
			sent += tuple_vals.size();
			send_tuple();
		end
	endtask

	mode_t   phase_mode[N_PHASES] = '{MODE_ALLDIFF, MODE_SUM, MODE_NVALUES, MODE_UNUSED,
		MODE_NVALUES, MODE_SUM, MODE_ALLDIFF, MODE_NVALUES};
	idling_t phase_idle[N_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
		IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

	initial begin : stimulus
		in_valid <= 1'b0;
		value <= '0;
		last <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= MODE_ALLDIFF;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed tuples, all without idling.
		write_mode(MODE_ALLDIFF);
		// A lone item is trivially all-distinct.
		tuple_vals = '{32'h8000_0000};
		send_tuple();
		// The top of the value range and minus one with a repeat, then a clean triple.
		tuple_vals = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
		send_tuple();
		tuple_vals = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF};
		send_tuple();
		// Exactly fills the store, then one distinct value too many.
		tuple_vals.delete();
		add_run(32'h8000_0000, 32'h0400_0001, SET_DEPTH);
		send_tuple();
		tuple_vals.delete();
		add_run(32'h8000_0000, 32'h0400_0001, SET_DEPTH + 1);
		send_tuple();

		write_mode(MODE_SUM);
		// Too short for a sum.
		tuple_vals = '{32'h0000_0005};
		send_tuple();
		// The sum wraps past the top of the range.
		tuple_vals = '{32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000};
		send_tuple();
		tuple_vals = '{32'h0000_0005, 32'h0000_0006, 32'h0000_000A};
		send_tuple();
		// The sum matches but the store overflowed, so it must not hold.
		tuple_vals.delete();
		add_run(32'd100, 32'd1, SET_DEPTH + 1);
		tuple_vals.push_back(32'd8580);
		send_tuple();

		write_mode(MODE_NVALUES);
		tuple_vals = '{32'd3, 32'd3, 32'd7, 32'd2};
		send_tuple();
		// Targets that are zero or negative are malformed, as is a lone item.
		tuple_vals = '{32'd1, 32'd0};
		send_tuple();
		tuple_vals = '{32'd1, 32'hFFFF_FFFF};
		send_tuple();
		tuple_vals = '{32'd1, 32'h8000_0000};
		send_tuple();
		tuple_vals = '{32'd5};
		send_tuple();
		// A full store meets its target; one more distinct value overflows it.
		tuple_vals.delete();
		add_run(-32'sd32, 32'd1, SET_DEPTH);
		tuple_vals.push_back(word_t'(SET_DEPTH));
		send_tuple();
		tuple_vals.delete();
		add_run(-32'sd32, 32'd1, SET_DEPTH + 1);
		tuple_vals.push_back(word_t'(SET_DEPTH));
		send_tuple();

		// The unused mode never holds and never reports malformed.
		write_mode(MODE_UNUSED);
		tuple_vals = '{32'd1, 32'd2, 32'd0};
		send_tuple();
		tuple_vals = '{32'd9};
		send_tuple();

		// Random phases, each with its own mode and idling pattern.
		for (int p = 0; p < N_PHASES; p++) begin
			write_mode(phase_mode[p]);
			set_idling(phase_idle[p]);
			if (p == 0) begin
				// Back-pressure: the receiver stops for a long stretch while
				// single-item tuples keep coming, so the block fills and stalls.
				hold_req = 1'b1;
				for (int i = 0; i < 24; i++)
					send_item(pick_value(FILL_SMALL), 1'b1);
			end
			run_phase(RANDOM_ITEMS / N_PHASES);
		end

		set_idling(IDLE_NONE);
		settle();
		$display("Run covered %0d input items and %0d tuple results in all four mode codes,",
			board.items_seen, board.verdicts_seen);
		$display("including store overflow, malformed tuples, sum wrap and long back-pressure.");
		if (board.errors == 0 && board.pending_verdicts.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Hard stop in case the block hangs on either handshake.
	initial begin : watchdog
		#(TIMEOUT_NS);
		$error("run did not complete in time, %0d results outstanding",
			board.pending_verdicts.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### global_constraint_checker.f
sv/gcc_pkg.sv
sv/gcc_ram.sv
sv/gcc_ctrl.sv
sv/gcc_dp.sv
sv/global_constraint_checker.sv
tb/tb_global_constraint_checker.sv
